>>> hdl/spp_pkg.sv
// Package with the types, codes and constants shared by the SUBACK parser files.
package spp_pkg;

    // Parse phases.
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_ID_HI   = 3'd2;
    localparam logic [2:0] PH_ID_LO   = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Status and latched error codes.
    localparam logic [2:0] ST_BUSY     = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_TYPE     = 3'd2;
    localparam logic [2:0] ST_LENFIELD = 3'd3;
    localparam logic [2:0] ST_MISMATCH = 3'd4;
    localparam logic [2:0] ST_CODE     = 3'd5;

    // Packet constants.
    localparam logic [7:0]  SUBACK_HEADER = 8'h90;
    localparam logic [7:0]  RC_FAILURE    = 8'h80;
    localparam logic [7:0]  RC_MAX_QOS    = 8'd2;
    localparam logic [27:0] MIN_REM_LEN   = 28'd2;
    localparam logic [2:0]  MAX_LEN_BYTES = 3'd4;

    // Parser state carried from one beat to the next.
    typedef struct packed {
        logic [2:0]  phase;
        logic [27:0] length_accum;
        logic [2:0]  length_bytes_seen;
        logic [27:0] bytes_left;
        logic [15:0] ident_reg;
        logic [27:0] index_count;
        logic [2:0]  error_code;
    } t_state;

    // One result beat.
    typedef struct packed {
        logic [2:0]  status;
        logic        done_res;
        logic        code_valid;
        logic [7:0]  return_code;
        logic [27:0] code_index;
        logic [15:0] packet_ident;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:             PH_HEADER,
        length_accum:      28'd0,
        length_bytes_seen: 3'd0,
        bytes_left:        28'd0,
        ident_reg:         16'd0,
        index_count:       28'd0,
        error_code:        ST_BUSY
    };

endpackage

>>> hdl/spp_step.sv
// Next-state and result logic for one byte of the SUBACK parser.
module spp_step
    import spp_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte_in,
    input  logic       i_is_last,
    output t_state     o_state,
    output t_result    o_result
);

    t_state      s;
    logic [27:0] len_part;
    logic [27:0] accum_next;
    logic [2:0]  seen_next;

    always_comb begin
        s          = i_state;
        len_part   = 28'd0;
        accum_next = i_state.length_accum;
        seen_next  = i_state.length_bytes_seen;

        o_result             = '0;
        o_result.status      = ST_BUSY;
        o_result.done_res    = i_is_last;

        // Advance the parse only while no error is latched.
        if (i_state.error_code == ST_BUSY) begin
            unique case (i_state.phase)
                PH_HEADER: begin
                    if (i_byte_in != SUBACK_HEADER) begin
                        s.error_code = ST_TYPE;
                    end else begin
                        s.phase = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    // Place the seven length bits by the number of length bytes seen.
                    case (i_state.length_bytes_seen[1:0])
                        2'd0:    len_part = {21'd0, i_byte_in[6:0]};
                        2'd1:    len_part = {14'd0, i_byte_in[6:0], 7'd0};
                        2'd2:    len_part = {7'd0, i_byte_in[6:0], 14'd0};
                        default: len_part = {i_byte_in[6:0], 21'd0};
                    endcase
                    accum_next          = i_state.length_accum | len_part;
                    seen_next           = i_state.length_bytes_seen + 3'd1;
                    s.length_accum      = accum_next;
                    s.length_bytes_seen = seen_next;
                    if (i_byte_in[7]) begin
                        if (seen_next >= MAX_LEN_BYTES) begin
                            s.error_code = ST_LENFIELD;
                        end
                    end else if (accum_next < MIN_REM_LEN) begin
                        s.error_code = ST_LENFIELD;
                    end else begin
                        s.bytes_left = accum_next;
                        s.phase      = PH_ID_HI;
                    end
                end
                PH_ID_HI, PH_ID_LO, PH_PAYLOAD: begin
                    if (i_state.bytes_left == 28'd0) begin
                        s.error_code = ST_MISMATCH;
                    end else begin
                        s.bytes_left = i_state.bytes_left - 28'd1;
                        if (i_state.phase == PH_ID_HI) begin
                            s.ident_reg = {i_byte_in, 8'd0};
                            s.phase     = PH_ID_LO;
                        end else if (i_state.phase == PH_ID_LO) begin
                            s.ident_reg = i_state.ident_reg | {8'd0, i_byte_in};
                            s.phase     = PH_PAYLOAD;
                        end else if (i_byte_in <= RC_MAX_QOS || i_byte_in == RC_FAILURE) begin
                            o_result.code_valid  = 1'b1;
                            o_result.return_code = i_byte_in;
                            o_result.code_index  = i_state.index_count;
                            s.index_count        = i_state.index_count + 28'd1;
                        end else begin
                            s.error_code = ST_CODE;
                        end
                    end
                end
                default: begin
                    s.error_code = ST_LENFIELD;
                end
            endcase
        end

        // Final verdict on the last byte of the packet.
        if (i_is_last) begin
            if (s.error_code != ST_BUSY) begin
                o_result.status = s.error_code;
            end else if (s.phase == PH_PAYLOAD && s.bytes_left == 28'd0) begin
                o_result.status = ST_OK;
            end else if (s.phase == PH_HEADER || s.phase == PH_LENGTH) begin
                o_result.status = ST_LENFIELD;
            end else begin
                o_result.status = ST_MISMATCH;
            end
        end

        o_result.packet_ident = s.ident_reg;

        // The parser starts over after the last byte.
        o_state = i_is_last ? STATE_RESET : s;
    end

endmodule

>>> hdl/suback_packet_parser_top.sv
// Top level of the streaming SUBACK packet parser.
// The parser takes one packet byte per beat and returns exactly one registered result beat
// for each, in the cycle after the byte is accepted; it sustains one byte every cycle while
// the output does not stall, set by the single state register that each byte updates, and
// keeps accepting while a result waits if that result register can move on in the same cycle.
// Return codes come out with their payload index; status is busy on every byte but the
// last, where it gives the verdict and the parser returns to its reset state.
module suback_packet_parser_top
    import spp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic        o_done_res,
    output logic        o_code_valid,
    output logic [7:0]  o_return_code,
    output logic [27:0] o_code_index,
    output logic [15:0] o_packet_ident
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    accept;

    spp_step u_step (
        .i_state   (r_state),
        .i_byte_in (i_byte_in),
        .i_is_last (i_is_last),
        .o_state   (n_state),
        .o_result  (n_result)
    );

    // A byte is taken whenever the result register is empty or drains this cycle.
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    always_comb begin
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    // Parser state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (accept) begin
                r_state <= n_state;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_result.status;
    assign o_done_res     = r_result.done_res;
    assign o_code_valid   = r_result.code_valid;
    assign o_return_code  = r_result.return_code;
    assign o_code_index   = r_result.code_index;
    assign o_packet_ident = r_result.packet_ident;

endmodule

>>> hdl/spp_checker.sv
// Port-level assertion checker for the SUBACK parser, bound to its top level.
module spp_checker
    import spp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic        o_done_res,
    input logic        o_code_valid,
    input logic [7:0]  o_return_code,
    input logic [27:0] o_code_index,
    input logic [15:0] o_packet_ident
);

    // A stalled result beat holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_code_index)
            && $stable(o_return_code) && $stable(o_packet_ident))
        else $error("stalled result beat changed");

    // Only the last byte of a packet carries a verdict.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_status == ST_BUSY) == !o_done_res))
        else $error("status does not match the last-byte flag");

    // An emitted return code is one of the legal codes.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_code_valid |-> (o_return_code <= RC_MAX_QOS
            || o_return_code == RC_FAILURE))
        else $error("illegal return code emitted");

    // Code fields are zero when no code is emitted.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_code_valid |-> o_return_code == 8'd0 && o_code_index == 28'd0)
        else $error("code fields not cleared");

    // The input is never stalled while the result register is empty.
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty result register");

endmodule

bind suback_packet_parser_top spp_checker u_spp_checker (.*);
